// ===== hdl/gsmm_pkg.sv =====
// gsmm_pkg: shared types and constants for the gas sensor median monitor
// register indexes, reset values, request codes and timer status struct
// no dependencies
package gsmm_pkg;

  localparam int LEVEL_W   = 10;
  localparam int THR_W     = 10;
  localparam int STREAK_W  = 16;
  localparam int PERIOD_W  = 16;
  localparam int PREHEAT_W = 24;
  localparam int SCNT_W    = 3;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_THR    = 3'd0,
    CFG_EDGE_LOW     = 3'd1,
    CFG_EDGE_HIGH    = 3'd2,
    CFG_STREAK_LIMIT = 3'd3,
    CFG_READ_PERIOD  = 3'd4,
    CFG_PREHEAT_MS   = 3'd5,
    CFG_SAMPLE_COUNT = 3'd6
  } cfg_idx_t;

  localparam logic [THR_W-1:0]     RST_ALARM_THR    = 10'd300;
  localparam logic [THR_W-1:0]     RST_EDGE_LOW     = 10'd5;
  localparam logic [THR_W-1:0]     RST_EDGE_HIGH    = 10'd1018;
  localparam logic [STREAK_W-1:0]  RST_STREAK_LIMIT = 16'd30;
  localparam logic [PERIOD_W-1:0]  RST_READ_PERIOD  = 16'd2000;
  localparam logic [PREHEAT_W-1:0] RST_PREHEAT_MS   = 24'd180000;
  localparam logic [SCNT_W-1:0]    RST_SAMPLE_COUNT = 3'd5;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // one accepted request as seen by the timers
  typedef struct packed {
    logic tick;
    logic sample;
  } tmr_ctrl_t;

  // timer status for the request being accepted
  typedef struct packed {
    logic preheat;  // preheat still running after the leading check
    logic reopen;   // this tick ends a read period
  } tmr_stat_t;

endpackage

// ===== hdl/gsmm_cell.sv =====
// gsmm_cell: one cell of the insertion sorting chain
// holds one sample and keeps it, takes the new value or takes its left neighbor's value
// depends on nothing but its parameter
module gsmm_cell #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         load,
  input  logic         valid,
  input  logic [W-1:0] x,
  input  logic [W-1:0] left_val,
  input  logic         left_gt,
  output logic [W-1:0] val,
  output logic         gt,
  output logic [W-1:0] nxt
);

  logic [W-1:0] val_r;

  // empty cells sort as larger than anything
  assign gt  = !valid || (val_r > x);
  assign val = val_r;
  assign nxt = !gt ? val_r : (!left_gt ? x : left_val);

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= nxt;
    end
  end

endmodule

// ===== hdl/gsmm_timer.sv =====
// gsmm_timer: preheat timer and read period timer driven by tick requests
// uses gsmm_pkg for widths and the control and status structs
module gsmm_timer
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  gsmm_pkg::tmr_ctrl_t        ctrl,
  input  logic [gsmm_pkg::PREHEAT_W-1:0] preheat_ms,
  input  logic [gsmm_pkg::PERIOD_W-1:0]  read_period_ms,
  output gsmm_pkg::tmr_stat_t        stat
);
  import gsmm_pkg::*;

  logic                 preheat_flag_r, preheat_flag_nxt;
  logic [PREHEAT_W-1:0] preheat_elapsed_r, preheat_elapsed_nxt;
  logic [PERIOD_W-1:0]  period_elapsed_r, period_elapsed_nxt;
  logic [PREHEAT_W-1:0] preheat_inc;
  logic [PERIOD_W-1:0]  period_inc;
  logic                 chk;

  // check made ahead of every request
  assign chk = preheat_flag_r && (preheat_elapsed_r < preheat_ms);

  assign preheat_inc = (&preheat_elapsed_r) ? preheat_elapsed_r
                                            : preheat_elapsed_r + 1'b1;
  assign period_inc  = (&period_elapsed_r) ? period_elapsed_r
                                           : period_elapsed_r + 1'b1;

  always_comb begin
    preheat_flag_nxt    = preheat_flag_r;
    preheat_elapsed_nxt = preheat_elapsed_r;
    period_elapsed_nxt  = period_elapsed_r;
    stat.preheat        = chk;
    stat.reopen         = 1'b0;
    if (ctrl.tick) begin
      preheat_elapsed_nxt = preheat_inc;
      preheat_flag_nxt    = chk && (preheat_inc < preheat_ms);
      if (period_inc >= read_period_ms) begin
        period_elapsed_nxt = '0;
        stat.reopen        = 1'b1;
      end else begin
        period_elapsed_nxt = period_inc;
      end
    end else if (ctrl.sample) begin
      preheat_flag_nxt = chk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preheat_flag_r    <= 1'b1;
      preheat_elapsed_r <= '0;
      period_elapsed_r  <= '0;
    end else begin
      preheat_flag_r    <= preheat_flag_nxt;
      preheat_elapsed_r <= preheat_elapsed_nxt;
      period_elapsed_r  <= period_elapsed_nxt;
    end
  end

endmodule

// ===== hdl/gas_sensor_median_monitor.sv =====
// gas_sensor_median_monitor: top level of the gas sensor median monitor
// uses gsmm_pkg, gsmm_cell (sorting chain) and gsmm_timer (preheat and period)
// holds the configuration registers, window control, judgement and output stage
//
// Requests are either one millisecond ticks or converter samples. Ticks run the
// preheat timer and the read period timer; the collection window is open after
// reset and reopens at the end of every read period, dropping a partial window.
// While the window is open each sample is inserted into a chain of sorting cells
// that keeps the window's samples in ascending order; the sample that fills the
// window (sample_count samples, clamped to 1..MAX_SAMPLES) yields the median,
// which is judged against the stuck-at-edge limits and the alarm threshold and
// emitted as one result. Ticks, partial-window samples and samples that arrive
// while the window is closed emit nothing. One request is taken every clock
// cycle while the result side keeps up: the sorting chain settles each insert
// combinationally, the median and its preheat state go through one register
// stage, and the judgement writes the output register. Configuration registers
// are written with cfg_we and must only change while no request is in flight.
module gas_sensor_median_monitor #(
  parameter int MAX_SAMPLES = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [SAMPLE_BITS-1:0]           in_adc_sample,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gsmm_pkg::LEVEL_W-1:0]     out_level,
  output logic                             out_preheating,
  output logic                             out_reading_sane,
  output logic                             out_gas_alarm,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [gsmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsmm_pkg::CFG_W-1:0]       cfg_wdata
);
  import gsmm_pkg::*;

  // sample counter must hold MAX_SAMPLES and the raw sample_count register
  localparam int CNT_RAW_W = $clog2(MAX_SAMPLES + 1);
  localparam int CNT_W     = (CNT_RAW_W > SCNT_W) ? CNT_RAW_W : SCNT_W;
  localparam int IDX_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CMP_W     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]     alarm_threshold_r;
  logic [THR_W-1:0]     edge_low_r;
  logic [THR_W-1:0]     edge_high_r;
  logic [STREAK_W-1:0]  edge_streak_limit_r;
  logic [PERIOD_W-1:0]  read_period_ms_r;
  logic [PREHEAT_W-1:0] preheat_ms_r;
  logic [SCNT_W-1:0]    sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_threshold_r   <= RST_ALARM_THR;
      edge_low_r          <= RST_EDGE_LOW;
      edge_high_r         <= RST_EDGE_HIGH;
      edge_streak_limit_r <= RST_STREAK_LIMIT;
      read_period_ms_r    <= RST_READ_PERIOD;
      preheat_ms_r        <= RST_PREHEAT_MS;
      sample_count_r      <= RST_SAMPLE_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALARM_THR:    alarm_threshold_r   <= cfg_wdata[THR_W-1:0];
        CFG_EDGE_LOW:     edge_low_r          <= cfg_wdata[THR_W-1:0];
        CFG_EDGE_HIGH:    edge_high_r         <= cfg_wdata[THR_W-1:0];
        CFG_STREAK_LIMIT: edge_streak_limit_r <= cfg_wdata[STREAK_W-1:0];
        CFG_READ_PERIOD:  read_period_ms_r    <= cfg_wdata[PERIOD_W-1:0];
        CFG_PREHEAT_MS:   preheat_ms_r        <= cfg_wdata[PREHEAT_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_r      <= cfg_wdata[SCNT_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and pipeline flow
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_adv;
  logic in_acc;
  logic tick_acc, smp_acc;

  // stage 1 moves on when the output register is empty or being drained
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_req_type == REQ_TICK);
  assign smp_acc  = in_acc && (in_req_type == REQ_SAMPLE);

  // ---------------------------------------------------------------------------
  // timers
  // ---------------------------------------------------------------------------
  tmr_ctrl_t tmr_ctrl;
  tmr_stat_t tmr_stat;

  assign tmr_ctrl.tick   = tick_acc;
  assign tmr_ctrl.sample = smp_acc;

  gsmm_timer u_timer (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (tmr_ctrl),
    .preheat_ms     (preheat_ms_r),
    .read_period_ms (read_period_ms_r),
    .stat           (tmr_stat)
  );

  // ---------------------------------------------------------------------------
  // collection window
  // ---------------------------------------------------------------------------
  logic             window_open_r, window_open_nxt;
  logic [CNT_W-1:0] taken_r, taken_nxt;
  logic [CNT_W-1:0] sc_ext;
  logic [CNT_W-1:0] win_cnt;
  logic [CNT_W-1:0] taken_inc;
  logic [CNT_W-1:0] mid;
  logic             load;
  logic             done;

  // window size clamped to 1..MAX_SAMPLES
  assign sc_ext = CNT_W'(sample_count_r);
  always_comb begin
    if (sc_ext > CNT_W'(MAX_SAMPLES)) begin
      win_cnt = CNT_W'(MAX_SAMPLES);
    end else if (sc_ext == '0) begin
      win_cnt = CNT_W'(1);
    end else begin
      win_cnt = sc_ext;
    end
  end

  assign mid       = win_cnt >> 1;
  assign load      = smp_acc && window_open_r;
  assign taken_inc = taken_r + 1'b1;
  assign done      = load && (taken_inc >= win_cnt);

  always_comb begin
    window_open_nxt = window_open_r;
    taken_nxt       = taken_r;
    if (tick_acc && tmr_stat.reopen) begin
      // new period, any partial window is dropped
      window_open_nxt = 1'b1;
      taken_nxt       = '0;
    end else if (done) begin
      window_open_nxt = 1'b0;
      taken_nxt       = '0;
    end else if (load) begin
      taken_nxt = taken_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r <= 1'b1;
      taken_r       <= '0;
    end else begin
      window_open_r <= window_open_nxt;
      taken_r       <= taken_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // sorting chain: cells stay in ascending order, empty cells at the top end
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cell_val [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] cell_nxt [MAX_SAMPLES];
  logic                   cell_gt  [MAX_SAMPLES];
  logic                   cell_vld [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_val;
    logic                   left_gt;

    assign cell_vld[i] = (taken_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_val = in_adc_sample;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    gsmm_cell #(
      .W (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .load     (load),
      .valid    (cell_vld[i]),
      .x        (in_adc_sample),
      .left_val (left_val),
      .left_gt  (left_gt),
      .val      (cell_val[i]),
      .gt       (cell_gt[i]),
      .nxt      (cell_nxt[i])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 1: median and preheat state of the completed window
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] s1_level_r;
  logic                   s1_preheat_r;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = done;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      s1_level_r   <= cell_nxt[mid[IDX_W-1:0]];
      s1_preheat_r <= tmr_stat.preheat;
    end
  end

  // ---------------------------------------------------------------------------
  // judgement: stuck-at-edge streak, sane flag and alarm
  // ---------------------------------------------------------------------------
  logic [STREAK_W-1:0] stuck_streak_r, stuck_streak_nxt;
  logic [STREAK_W-1:0] streak_inc;
  logic                sane_r, sane_nxt;
  logic [CMP_W-1:0]    lvl_ext;
  logic                stuck;
  logic                judge;

  assign judge      = s1_valid_r && s1_adv;
  assign lvl_ext    = CMP_W'(s1_level_r);
  assign stuck      = (lvl_ext < CMP_W'(edge_low_r)) || (lvl_ext > CMP_W'(edge_high_r));
  assign streak_inc = (stuck_streak_r < edge_streak_limit_r) ? stuck_streak_r + 1'b1
                                                             : stuck_streak_r;

  always_comb begin
    stuck_streak_nxt = stuck_streak_r;
    sane_nxt         = sane_r;
    if (judge) begin
      if (s1_preheat_r) begin
        stuck_streak_nxt = '0;
      end else if (stuck) begin
        stuck_streak_nxt = streak_inc;
        if (streak_inc >= edge_streak_limit_r) begin
          sane_nxt = 1'b0;
        end
      end else begin
        stuck_streak_nxt = '0;
        sane_nxt         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuck_streak_r <= '0;
      sane_r         <= 1'b1;
    end else begin
      stuck_streak_r <= stuck_streak_nxt;
      sane_r         <= sane_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_preheat_r;
  logic               out_sane_r;
  logic               out_alarm_r;

  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (judge) begin
      out_level_r   <= LEVEL_W'(s1_level_r);
      out_preheat_r <= s1_preheat_r;
      out_sane_r    <= sane_nxt;
      out_alarm_r   <= !s1_preheat_r && sane_nxt &&
                       (lvl_ext > CMP_W'(alarm_threshold_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_preheating   = out_preheat_r;
  assign out_reading_sane = out_sane_r;
  assign out_gas_alarm    = out_alarm_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a full window always closes, so the fill count stays below the cell count
  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r < CNT_W'(MAX_SAMPLES))
    else $error("window fill count reached the cell count");

  // a closed window holds no partial samples
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !window_open_r |-> (taken_r == '0))
    else $error("closed window still counts samples");

  // occupied cells stay in ascending order
  for (genvar k = 1; k < MAX_SAMPLES; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      cell_vld[k] |-> (cell_val[k-1] <= cell_val[k]))
      else $error("sorting chain out of order");
  end

endmodule

// ===== tb/sv/gsmm_sb_pkg.sv =====
`timescale 1ns / 100ps
// gsmm_sb_pkg: result predictor and checker for the gas sensor median monitor tb
// depends on gsmm_pkg for widths, register indexes and request codes
package gsmm_sb_pkg;
  import gsmm_pkg::*;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               preheating;
    logic               sane;
    logic               alarm;
  } verdict_t;

  class median_scoreboard;
    // register mirror
    logic [THR_W-1:0]     thr;
    logic [THR_W-1:0]     lo_edge;
    logic [THR_W-1:0]     hi_edge;
    logic [STREAK_W-1:0]  streak_cap;
    logic [PERIOD_W-1:0]  period_len;
    logic [PREHEAT_W-1:0] preheat_len;
    logic [SCNT_W-1:0]    win_size_cfg;
    // block state
    bit                   warming;
    logic [PREHEAT_W-1:0] warm_ticks;
    logic [PERIOD_W-1:0]  period_ticks;
    bit                   win_open;
    logic [LEVEL_W-1:0]   win_vals[5];
    int                   win_fill;
    logic [STREAK_W-1:0]  streak;
    bit                   sane;

    verdict_t expected_verdicts[$];
    int errors, requests, checked, alarms, insane_seen;

    function new();
      thr = RST_ALARM_THR;
      lo_edge = RST_EDGE_LOW;
      hi_edge = RST_EDGE_HIGH;
      streak_cap = RST_STREAK_LIMIT;
      period_len = RST_READ_PERIOD;
      preheat_len = RST_PREHEAT_MS;
      win_size_cfg = RST_SAMPLE_COUNT;
      warming = 1;
      warm_ticks = '0;
      period_ticks = '0;
      win_open = 1;
      win_fill = 0;
      streak = '0;
      sane = 1;
      foreach (win_vals[i]) win_vals[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ALARM_THR:    thr = val[THR_W-1:0];
        CFG_EDGE_LOW:     lo_edge = val[THR_W-1:0];
        CFG_EDGE_HIGH:    hi_edge = val[THR_W-1:0];
        CFG_STREAK_LIMIT: streak_cap = val[STREAK_W-1:0];
        CFG_READ_PERIOD:  period_len = val[PERIOD_W-1:0];
        CFG_PREHEAT_MS:   preheat_len = val[PREHEAT_W-1:0];
        CFG_SAMPLE_COUNT: win_size_cfg = val[SCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void update_warmup();
      if (warming && warm_ticks >= preheat_len) warming = 0;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // advance the mirror by one accepted request, queue the verdict if a window completes
    function void note_request(logic rt, logic [LEVEL_W-1:0] smp);
      int n, i, j;
      logic [LEVEL_W-1:0] srt[5];
      logic [LEVEL_W-1:0] v, lvl;
      verdict_t vd;
      requests++;
      update_warmup();
      if (rt == REQ_TICK) begin
        if (warm_ticks != {PREHEAT_W{1'b1}}) warm_ticks++;
        update_warmup();
        if (period_ticks != {PERIOD_W{1'b1}}) period_ticks++;
        if (period_ticks >= period_len) begin
          period_ticks = '0;
          win_open = 1;
          win_fill = 0;
        end
        return;
      end
      if (!win_open) return;
      n = (win_size_cfg > 5) ? 5 : ((win_size_cfg < 1) ? 1 : int'(win_size_cfg));
      if (win_fill < 5) win_vals[win_fill] = smp;
      win_fill++;
      if (win_fill < n) return;
      srt = win_vals;
      for (i = 1; i < n; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      lvl = srt[n/2];
      win_open = 0;
      win_fill = 0;
      if (warming) begin
        streak = '0;
      end else if (lvl < lo_edge || lvl > hi_edge) begin
        if (streak < streak_cap) streak++;
        if (streak >= streak_cap) sane = 0;
      end else begin
        streak = '0;
        sane = 1;
      end
      vd.level = lvl;
      vd.preheating = warming;
      vd.sane = sane;
      vd.alarm = !warming && sane && (lvl > thr);
      expected_verdicts.push_back(vd);
    endfunction

    function void check_result(logic [LEVEL_W-1:0] lvl, logic ph, logic sn, logic al);
      verdict_t vd;
      if (expected_verdicts.size() == 0) begin
        $error("result with no request waiting: level %0d", lvl);
        errors++;
        return;
      end
      vd = expected_verdicts.pop_front();
      checked++;
      if (vd.alarm) alarms++;
      if (!vd.sane) insane_seen++;
      if (lvl !== vd.level) begin
        $error("level: expected %0d, actual %0d", vd.level, lvl);
        errors++;
      end
      if (ph !== vd.preheating) begin
        $error("preheating: expected %0b, actual %0b", vd.preheating, ph);
        errors++;
      end
      if (sn !== vd.sane) begin
        $error("reading_sane: expected %0b, actual %0b", vd.sane, sn);
        errors++;
      end
      if (al !== vd.alarm) begin
        $error("gas_alarm: expected %0b, actual %0b", vd.alarm, al);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: top level testbench for gas_sensor_median_monitor, directed then random requests
// depends on gsmm_pkg and gsmm_sb_pkg (median_scoreboard)
module tb;
  import gsmm_pkg::*;
  import gsmm_sb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;  // no register behind it
  localparam int RANDOM_REQUESTS = 1450;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = REQ_TICK;
  logic [LEVEL_W-1:0]   in_adc_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LEVEL_W-1:0]   out_level;
  logic                 out_preheating;
  logic                 out_reading_sane;
  logic                 out_gas_alarm;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  median_scoreboard sb = new();

  // per phase knobs for idling and sample flavor
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int stuck_pct = 30;
  int random_sent = 0;
  int phases = 0;

  gas_sensor_median_monitor u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_level        (out_level),
    .out_preheating   (out_preheating),
    .out_reading_sane (out_reading_sane),
    .out_gas_alarm    (out_gas_alarm),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // result side backpressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor, samples pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_level, out_preheating, out_reading_sane, out_gas_alarm);
  end

  // watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // stuck flavor hugs the rails, plain flavor spans the full range
  function automatic logic [LEVEL_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < stuck_pct / 2) return LEVEL_W'($urandom_range(0, 8));
    if (r < stuck_pct) return LEVEL_W'($urandom_range(1015, 1023));
    if (r < stuck_pct + 5) return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    return LEVEL_W'($urandom_range(0, 1023));
  endfunction

  // one request; valid stays high into the next request when there is no gap
  task automatic send_request(logic rt, logic [LEVEL_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_adc_sample <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rt, smp);
  endtask

  // leaves cfg_we high, the caller drops it after the last write
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] word;
    case (idx)
      CFG_ALARM_THR, CFG_EDGE_LOW, CFG_EDGE_HIGH: mask = 24'h0003FF;
      CFG_STREAK_LIMIT, CFG_READ_PERIOD:          mask = 24'h00FFFF;
      CFG_SAMPLE_COUNT:                           mask = 24'h000007;
      default:                                    mask = 24'hFFFFFF;
    endcase
    word = val & mask;
    // junk above the register width must be dropped
    if ($urandom_range(0, 1) != 0) word = word | (CFG_W'($urandom()) & ~mask);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    sb.write_reg(idx, word);
  endtask

  // fill a half-done window so sample_count never changes under a partial window
  task automatic complete_window();
    while (sb.win_open && sb.win_fill != 0) send_request(REQ_SAMPLE, pick_sample());
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase();
    int target, n;
    logic [CFG_W-1:0] per;
    complete_window();
    settle();
    phases++;
    case ($urandom_range(0, 9))
      0: set_reg(CFG_ALARM_THR, 0);
      1: set_reg(CFG_ALARM_THR, 1023);
      default: set_reg(CFG_ALARM_THR, CFG_W'($urandom_range(200, 900)));
    endcase
    case ($urandom_range(0, 9))
      0: set_reg(CFG_EDGE_LOW, 0);
      1: set_reg(CFG_EDGE_LOW, 1023);
      default: set_reg(CFG_EDGE_LOW, CFG_W'($urandom_range(1, 12)));
    endcase
    case ($urandom_range(0, 9))
      0: set_reg(CFG_EDGE_HIGH, 0);
      1: set_reg(CFG_EDGE_HIGH, 1023);
      default: set_reg(CFG_EDGE_HIGH, CFG_W'($urandom_range(1010, 1022)));
    endcase
    case ($urandom_range(0, 9))
      0: set_reg(CFG_STREAK_LIMIT, 0);
      1: set_reg(CFG_STREAK_LIMIT, 65535);
      2: set_reg(CFG_STREAK_LIMIT, CFG_W'($urandom_range(1, 65535)));
      default: set_reg(CFG_STREAK_LIMIT, CFG_W'($urandom_range(1, 6)));
    endcase
    case ($urandom_range(0, 11))
      0: per = 0;
      1: per = 65535;
      2: per = CFG_W'($urandom_range(13, 300));
      default: per = CFG_W'($urandom_range(1, 12));
    endcase
    set_reg(CFG_READ_PERIOD, per);
    case ($urandom_range(0, 3))
      0: set_reg(CFG_PREHEAT_MS, 0);
      1: set_reg(CFG_PREHEAT_MS, 24'hFFFFFF);
      default: set_reg(CFG_PREHEAT_MS, CFG_W'($urandom()));
    endcase
    set_reg(CFG_SAMPLE_COUNT, CFG_W'($urandom_range(0, 7)));
    cfg_we <= 1'b0;

    // idling mix, with some phases running flat out
    case ($urandom_range(0, 3))
      0: gap_pct = 0;
      1: gap_pct = 15;
      default: gap_pct = $urandom_range(5, 50);
    endcase
    case ($urandom_range(0, 3))
      0: stall_pct = 0;
      1: stall_pct = 15;
      default: stall_pct = $urandom_range(5, 50);
    endcase
    stuck_pct = ($urandom_range(0, 2) == 0) ? 80 : 20;

    target = (sb.period_len > 300) ? 80 : $urandom_range(60, 160);
    n = 0;
    while (n < target) begin
      // open window: mostly samples with a stray tick; closed: mostly ticks
      if (sb.win_open ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 12)) begin
        if (sb.win_open) n++;
        send_request(REQ_SAMPLE, pick_sample());
      end else begin
        n++;
        send_request(REQ_TICK, LEVEL_W'($urandom_range(0, 1023)));
      end
    end
    random_sent += n;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, still preheating: five-sample median of near-rail values and one midscale value
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd512);
    send_request(REQ_SAMPLE, 10'd1);
    send_request(REQ_SAMPLE, 10'd1022);
    // window is closed now, this one is dropped
    send_request(REQ_SAMPLE, 10'd7);
    send_request(REQ_TICK, 10'd0);

    // zero sample count acts as one, zero period reopens on every tick,
    // zero streak limit; stuck medians during preheat keep the streak at zero
    settle();
    set_reg(CFG_SAMPLE_COUNT, 0);
    set_reg(CFG_READ_PERIOD, 0);
    set_reg(CFG_STREAK_LIMIT, 0);
    set_reg(CFG_ALARM_THR, 0);
    set_reg(CFG_SPARE_IDX, CFG_W'($urandom()));
    cfg_we <= 1'b0;
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd1023);

    // zero preheat ends preheat at the very next request
    settle();
    set_reg(CFG_PREHEAT_MS, 0);
    cfg_we <= 1'b0;
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd600);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd0);

    // oversized sample count clamps to five, edges at the rails, top threshold
    settle();
    set_reg(CFG_SAMPLE_COUNT, 7);
    set_reg(CFG_READ_PERIOD, 2);
    set_reg(CFG_STREAK_LIMIT, 2);
    set_reg(CFG_ALARM_THR, 1023);
    set_reg(CFG_EDGE_LOW, 0);
    set_reg(CFG_EDGE_HIGH, 1023);
    set_reg(CFG_PREHEAT_MS, 24'hFFFFFF);
    cfg_we <= 1'b0;
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd1023);
    send_request(REQ_SAMPLE, 10'd0);
    send_request(REQ_SAMPLE, 10'd0);

    while (random_sent < RANDOM_REQUESTS) random_phase();

    settle();
    $display("%0d requests over %0d random settings, %0d medians checked",
             sb.requests, phases, sb.checked);
    $display("%0d medians raised the alarm, %0d came out with the reading insane",
             sb.alarms, sb.insane_seen);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gsmm_pkg.sv
hdl/gsmm_cell.sv
hdl/gsmm_timer.sv
hdl/gas_sensor_median_monitor.sv
tb/sv/gsmm_sb_pkg.sv
tb/sv/tb.sv
